// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define ASSERT_OFF to drop them all.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clk_i edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/tsk_pkg.sv =====
package tsk_pkg;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned EST_W     = 32;
  localparam int unsigned VAR_W     = 32;
  localparam int unsigned NOISE_W   = 16;
  localparam int unsigned PNOISE_SH = 4;
  localparam int unsigned RANGE_W   = 2;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned OUT_SH    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // serial datapath widths
  localparam int unsigned GAIN_W  = FRAC_W + 1;   // gain 0..1.0 in Q1.16
  localparam int unsigned DEN_W   = VAR_W + 1;    // p1 + (noise << 16)
  localparam int unsigned REM_W   = DEN_W + 1;    // divider partial remainder
  localparam int unsigned MCAND_W = EST_W + 2;    // innovation, signed
  localparam int unsigned PROD_W  = MCAND_W + 1;  // scaled product, signed
  localparam int unsigned STEP_W  = 5;

  localparam int unsigned IN_DATA_W  = ((NUM_AXES * SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((NUM_AXES * OUT_W + 1 + 7) / 8) * 8;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GAIN_W - 1);

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  localparam logic [VAR_W-1:0]  VAR_THRESHOLD = 32'd655;
  localparam logic [VAR_W-1:0]  VAR_ONE       = 32'h0001_0000;
  localparam logic [GAIN_W-1:0] GAIN_ONE      = 17'h1_0000;

  localparam logic [RANGE_W-1:0] RANGE_RST    = 2'd0;
  localparam logic [NOISE_W-1:0] PNOISE_RST   = 16'd6144;
  localparam logic [NOISE_W-1:0] MNOISE_X_RST = 16'd97;
  localparam logic [NOISE_W-1:0] MNOISE_Y_RST = 16'd140;
  localparam logic [NOISE_W-1:0] MNOISE_Z_RST = 16'd133;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE    = 3'd0,
    REG_PNOISE   = 3'd1,
    REG_MNOISE_X = 3'd2,
    REG_MNOISE_Y = 3'd3,
    REG_MNOISE_Z = 3'd4
  } cfg_reg_e;

  // Starting estimate: (32768 >> (range + 1)) in Q16.16.
  function automatic logic signed [EST_W-1:0] init_estimate(input logic [RANGE_W-1:0] rng);
    logic signed [EST_W-1:0] val;
    unique case (rng)
      2'd0: val = 32'sh4000_0000;
      2'd1: val = 32'sh2000_0000;
      2'd2: val = 32'sh1000_0000;
      2'd3: val = 32'sh0800_0000;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/tsk_div.sv =====
// Restoring divider, one quotient bit per cycle, MSB first.
// quo = floor(num * 2^16 / den), valid when done_o pulses; needs num <= den.
module tsk_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tsk_pkg::VAR_W-1:0]     num_i,
  input  logic [tsk_pkg::DEN_W-1:0]     den_i,
  output logic [tsk_pkg::GAIN_W-1:0]    quo_o,
  output logic                          done_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [tsk_pkg::STEP_W-1:0]    step_q, step_d;
  logic [tsk_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [tsk_pkg::DEN_W-1:0]     den_q, den_d;
  logic [tsk_pkg::GAIN_W-1:0]    quo_q, quo_d;

  logic [tsk_pkg::REM_W-1:0]     den_ext;
  logic [tsk_pkg::REM_W-1:0]     rem_sub;
  logic [tsk_pkg::REM_W-1:0]     rem_sel;
  logic                          ge;

  assign den_ext = {1'b0, den_q};
  assign ge      = (rem_q >= den_ext);
  assign rem_sub = rem_q - den_ext;
  assign rem_sel = ge ? rem_sub : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = {{(tsk_pkg::REM_W - tsk_pkg::VAR_W){1'b0}}, num_i};
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      // keep the remainder below den, then double it for the next bit
      rem_d = {rem_sel[tsk_pkg::REM_W-2:0], 1'b0};
      quo_d = {quo_q[tsk_pkg::GAIN_W-2:0], ge};
      if (step_q == tsk_pkg::LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/tsk_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// prod = floor(mcand * mplier / 2^16); the accumulator halves after every
// bit but the last, so the dropped bits give exact floor rounding.
module tsk_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tsk_pkg::MCAND_W-1:0]   mcand_i,
  input  logic [tsk_pkg::GAIN_W-1:0]           mplier_i,
  output logic signed [tsk_pkg::PROD_W-1:0]    prod_o,
  output logic                                 done_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [tsk_pkg::STEP_W-1:0]          step_q, step_d;
  logic signed [tsk_pkg::PROD_W-1:0]   acc_q, acc_d;
  logic signed [tsk_pkg::MCAND_W-1:0]  mcand_q, mcand_d;
  logic [tsk_pkg::GAIN_W-1:0]          mplier_q, mplier_d;

  logic signed [tsk_pkg::PROD_W-1:0]   addend;
  logic signed [tsk_pkg::PROD_W-1:0]   sum;

  assign addend = mplier_q[0] ? {mcand_q[tsk_pkg::MCAND_W-1], mcand_q} : '0;
  assign sum    = acc_q + addend;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    step_d   = step_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      step_d   = '0;
      acc_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
    end else if (busy_q) begin
      mplier_d = mplier_q >> 1;
      if (step_q == tsk_pkg::LAST_STEP) begin
        acc_d  = sum;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d  = sum >>> 1;
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/three_axis_scalar_kalman.sv =====
// Three-axis scalar Kalman smoother for accelerometer samples. Each request
// carries one signed 16-bit sample per axis; each result carries the three
// updated estimates as signed Q16.8 plus an all_settled flag that is high once
// every axis variance has dropped to 0.01 or below (such an axis is frozen).
// Axes are worked one after another through a shared bit-serial divider for
// the gain and two bit-serial multipliers for the estimate and variance
// updates. An active axis passes through setup, divide and multiply steps,
// while a frozen axis is skipped at its setup step. Once the result is
// loaded, the block goes back to idle and can take the next request. The
// result sits in an output register, so the next request is taken while the
// previous result still waits. A configuration write (registers: 0 range,
// 1 process noise, 2..4 measurement noise x/y/z) restarts every estimate at
// 32768 >> (range + 1) and every variance at 1.0; writes to other indexes
// are accepted and ignored. Configuration is taken only while idle, and a
// write offered in the same cycle as a request goes first.
`include "assert_macros.svh"

module three_axis_scalar_kalman (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request: sample_x, sample_y, sample_z (16 bits each, from bit 0 up)
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [tsk_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // result: filtered_x, filtered_y, filtered_z (24 bits each), all_settled,
  // then zero fill, from bit 0 up
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [tsk_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tsk_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tsk_pkg::NOISE_W-1:0]         cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIVS = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [tsk_pkg::RANGE_W-1:0]  range_q;
  logic [tsk_pkg::NOISE_W-1:0]  pnoise_q;
  logic [tsk_pkg::NOISE_W-1:0]  mnoise_q [tsk_pkg::NUM_AXES];

  // filter state per axis
  logic signed [tsk_pkg::EST_W-1:0] est_q [tsk_pkg::NUM_AXES];
  logic [tsk_pkg::VAR_W-1:0]        var_q [tsk_pkg::NUM_AXES];

  // current request
  logic signed [tsk_pkg::SAMPLE_W-1:0] samp_q [tsk_pkg::NUM_AXES];
  logic [tsk_pkg::AXIS_W-1:0]          ax_q, ax_d;

  // per-axis working values
  logic [tsk_pkg::VAR_W-1:0]            p1_q, p1_d;
  logic signed [tsk_pkg::MCAND_W-1:0]   innov_q, innov_d;

  // output register
  logic                                 m_valid_q, m_valid_d;
  logic [tsk_pkg::OUT_DATA_W-1:0]       m_data_q, m_data_d;

  logic s_fire, cfg_fire, cfg_hit, out_free;

  logic [tsk_pkg::RANGE_W-1:0]          range_new;
  logic signed [tsk_pkg::EST_W-1:0]     est_init;

  logic [tsk_pkg::VAR_W-1:0]            cur_var;
  logic signed [tsk_pkg::EST_W-1:0]     cur_est;
  logic                                 cur_active;
  logic [tsk_pkg::VAR_W:0]              p1_sum;
  logic signed [tsk_pkg::MCAND_W-1:0]   samp_ext, est_ext;
  logic [tsk_pkg::DEN_W-1:0]            den;

  logic                                 div_start, div_done;
  logic [tsk_pkg::GAIN_W-1:0]           div_quo;
  logic                                 mul_start, est_mul_done, var_mul_done;
  logic signed [tsk_pkg::PROD_W-1:0]    est_prod, var_prod;

  logic signed [tsk_pkg::PROD_W:0]      x_sum;
  logic [tsk_pkg::PROD_W-tsk_pkg::EST_W+1:0] x_top;
  logic signed [tsk_pkg::EST_W-1:0]     x_new;
  logic                                 store;
  logic                                 settled;

  // ---------------------------------------------------------------- handshakes
  // hold off a request while a configuration write is offered
  assign s_axis_tready_o = (state_q == ST_IDLE) & ~cfg_valid_i;
  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;
  assign cfg_hit         = cfg_fire & (cfg_index_i <= tsk_pkg::REG_MNOISE_Z);
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // the restart uses the range being written, if that is the register hit
  assign range_new = (tsk_pkg::cfg_reg_e'(cfg_index_i) == tsk_pkg::REG_RANGE) ?
                     cfg_data_i[tsk_pkg::RANGE_W-1:0] : range_q;
  assign est_init  = tsk_pkg::init_estimate(range_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q     <= tsk_pkg::RANGE_RST;
      pnoise_q    <= tsk_pkg::PNOISE_RST;
      mnoise_q[0] <= tsk_pkg::MNOISE_X_RST;
      mnoise_q[1] <= tsk_pkg::MNOISE_Y_RST;
      mnoise_q[2] <= tsk_pkg::MNOISE_Z_RST;
    end else if (cfg_fire) begin
      unique case (tsk_pkg::cfg_reg_e'(cfg_index_i))
        tsk_pkg::REG_RANGE:    range_q     <= cfg_data_i[tsk_pkg::RANGE_W-1:0];
        tsk_pkg::REG_PNOISE:   pnoise_q    <= cfg_data_i;
        tsk_pkg::REG_MNOISE_X: mnoise_q[0] <= cfg_data_i;
        tsk_pkg::REG_MNOISE_Y: mnoise_q[1] <= cfg_data_i;
        tsk_pkg::REG_MNOISE_Z: mnoise_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- axis setup
  assign cur_var    = var_q[ax_q];
  assign cur_est    = est_q[ax_q];
  assign cur_active = (cur_var > tsk_pkg::VAR_THRESHOLD);

  // predicted variance, saturated at all ones
  assign p1_sum = {1'b0, cur_var} +
                  (tsk_pkg::VAR_W+1)'({pnoise_q, {tsk_pkg::PNOISE_SH{1'b0}}});

  // innovation: (sample << 16) - estimate
  assign samp_ext = {{(tsk_pkg::MCAND_W - tsk_pkg::SAMPLE_W - tsk_pkg::FRAC_W)
                      {samp_q[ax_q][tsk_pkg::SAMPLE_W-1]}},
                     samp_q[ax_q], {tsk_pkg::FRAC_W{1'b0}}};
  assign est_ext  = {{(tsk_pkg::MCAND_W - tsk_pkg::EST_W){cur_est[tsk_pkg::EST_W-1]}},
                     cur_est};

  always_comb begin
    p1_d    = p1_q;
    innov_d = innov_q;
    if (state_q == ST_PREP) begin
      p1_d    = p1_sum[tsk_pkg::VAR_W] ? '1 : p1_sum[tsk_pkg::VAR_W-1:0];
      innov_d = samp_ext - est_ext;
    end
  end

  // gain denominator: p1 + (meas_noise << 16)
  assign den = {1'b0, p1_q} +
               {1'b0, mnoise_q[ax_q], {tsk_pkg::FRAC_W{1'b0}}};

  assign div_start = (state_q == ST_DIVS);
  assign mul_start = (state_q == ST_DIV) & div_done;

  tsk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p1_q),
    .den_i   (den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // estimate step: gain * innovation
  tsk_mul u_est_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (innov_q),
    .mplier_i (div_quo),
    .prod_o   (est_prod),
    .done_o   (est_mul_done)
  );

  // variance update: (1 - gain) * p1
  tsk_mul u_var_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  ({{(tsk_pkg::MCAND_W - tsk_pkg::VAR_W){1'b0}}, p1_q}),
    .mplier_i (tsk_pkg::GAIN_ONE - div_quo),
    .prod_o   (var_prod),
    .done_o   (var_mul_done)
  );

  // new estimate, clamped to the 32-bit signed range
  assign x_sum = {{(tsk_pkg::PROD_W + 1 - tsk_pkg::EST_W){cur_est[tsk_pkg::EST_W-1]}},
                  cur_est} +
                 {est_prod[tsk_pkg::PROD_W-1], est_prod};
  assign x_top = x_sum[tsk_pkg::PROD_W:tsk_pkg::EST_W-1];

  always_comb begin
    if ((&x_top) | ~(|x_top)) begin
      x_new = x_sum[tsk_pkg::EST_W-1:0];
    end else if (x_sum[tsk_pkg::PROD_W]) begin
      x_new = {1'b1, {(tsk_pkg::EST_W-1){1'b0}}};
    end else begin
      x_new = {1'b0, {(tsk_pkg::EST_W-1){1'b1}}};
    end
  end

  assign store = (state_q == ST_MUL) & est_mul_done;

  // ---------------------------------------------------------------- filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsk_pkg::NUM_AXES; i++) begin
        est_q[i] <= tsk_pkg::init_estimate(tsk_pkg::RANGE_RST);
        var_q[i] <= tsk_pkg::VAR_ONE;
      end
    end else if (cfg_hit) begin
      for (int i = 0; i < tsk_pkg::NUM_AXES; i++) begin
        est_q[i] <= est_init;
        var_q[i] <= tsk_pkg::VAR_ONE;
      end
    end else if (store) begin
      est_q[ax_q] <= x_new;
      var_q[ax_q] <= var_prod[tsk_pkg::VAR_W-1:0];
    end
  end

  // hold the samples of the request in flight
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      for (int i = 0; i < tsk_pkg::NUM_AXES; i++) begin
        samp_q[i] <= s_axis_tdata_i[i*tsk_pkg::SAMPLE_W +: tsk_pkg::SAMPLE_W];
      end
    end
    p1_q    <= p1_d;
    innov_q <= innov_d;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          ax_d    = '0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // skip a frozen axis
        if (cur_active) begin
          state_d = ST_DIVS;
        end else if (ax_q == tsk_pkg::AXIS_LAST) begin
          state_d = ST_OUT;
        end else begin
          ax_d = ax_q + 1'b1;
        end
      end
      ST_DIVS: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (est_mul_done) begin
          if (ax_q == tsk_pkg::AXIS_LAST) begin
            state_d = ST_OUT;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = ST_PREP;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    settled = 1'b1;
    for (int i = 0; i < tsk_pkg::NUM_AXES; i++) begin
      if (var_q[i] > tsk_pkg::VAR_THRESHOLD) begin
        settled = 1'b0;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q & m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if ((state_q == ST_OUT) & out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = '0;
      // Q16.16 floored to Q16.8 always fits 24 bits
      for (int i = 0; i < tsk_pkg::NUM_AXES; i++) begin
        m_data_d[i*tsk_pkg::OUT_W +: tsk_pkg::OUT_W] =
          est_q[i][tsk_pkg::EST_W-1 -: tsk_pkg::OUT_W];
      end
      m_data_d[tsk_pkg::NUM_AXES*tsk_pkg::OUT_W] = settled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_CLK(a_req_starts_axis0, s_fire |=> (state_q == ST_PREP) && (ax_q == '0),
              "accepted request did not start at the first axis")
  `ASSERT_NEVER(a_axis_in_range, ax_q > tsk_pkg::AXIS_LAST, "axis index out of range")
  `ASSERT_CLK(a_div_done_in_div, div_done |-> state_q == ST_DIV,
              "divider finished outside the divide step")
  `ASSERT_CLK(a_mul_lockstep, est_mul_done == var_mul_done,
              "estimate and variance multipliers out of step")
  `ASSERT_CLK(a_gain_bound, div_done |-> div_quo <= tsk_pkg::GAIN_ONE,
              "gain above one")
  `ASSERT_CLK(a_var_not_grown,
              var_mul_done |-> (var_prod[tsk_pkg::PROD_W-1:tsk_pkg::VAR_W] == '0) &&
                               (var_prod[tsk_pkg::VAR_W-1:0] <= p1_q),
              "updated variance exceeds predicted variance")

endmodule

// ===== tb/sv/tb_three_axis_scalar_kalman.sv =====
module tb_three_axis_scalar_kalman;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape: a short directed walk, then random phases, each with its own register set.
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 185;
  localparam int unsigned NOISE_SPAN  = 64;     // sensor jitter around a slowly moving level
  localparam int unsigned HOLD_AT     = 60;     // result count at which the sink holds off
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned END_PAD     = 150;    // a bit more than one full three-axis update
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned LIMIT_NS    = 30_000_000;

  // Register values after reset.
  localparam logic [tsk_pkg::NOISE_W-1:0] DEF_PNOISE   = 16'd6144;
  localparam logic [tsk_pkg::NOISE_W-1:0] DEF_MNOISE_X = 16'd97;
  localparam logic [tsk_pkg::NOISE_W-1:0] DEF_MNOISE_Y = 16'd140;
  localparam logic [tsk_pkg::NOISE_W-1:0] DEF_MNOISE_Z = 16'd133;

  // Indexes past the last register: the block takes the write and drops it.
  localparam logic [tsk_pkg::CFG_IDX_W-1:0] REG_SPARE_LO =
    tsk_pkg::CFG_IDX_W'(int'(tsk_pkg::REG_MNOISE_Z) + 1);
  localparam logic [tsk_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  localparam longint EST_MAX = (64'sd1 <<< (tsk_pkg::EST_W - 1)) - 1;
  localparam longint EST_MIN = -(64'sd1 <<< (tsk_pkg::EST_W - 1));
  localparam longint OUT_MAX = (64'sd1 <<< (tsk_pkg::OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(64'sd1 <<< (tsk_pkg::OUT_W - 1));

  // One result as it sits in the low bits of m_axis_tdata_o.
  typedef struct packed {
    logic                      settled;
    logic [tsk_pkg::OUT_W-1:0] fz;
    logic [tsk_pkg::OUT_W-1:0] fy;
    logic [tsk_pkg::OUT_W-1:0] fx;
  } filt_res_t;

  typedef enum logic {OP_SAMPLE, OP_WRITE} dir_op_e;

  typedef struct packed {
    dir_op_e                              op;
    logic [tsk_pkg::CFG_IDX_W-1:0]        idx;
    logic [tsk_pkg::NOISE_W-1:0]          wdata;
    logic signed [tsk_pkg::SAMPLE_W-1:0]  sx;
    logic signed [tsk_pkg::SAMPLE_W-1:0]  sy;
    logic signed [tsk_pkg::SAMPLE_W-1:0]  sz;
    logic                                 typed;   // use "want" instead of the filter model
    filt_res_t                            want;
  } dir_row_t;

  // Hand-computed results. With zero measurement noise the gain is exactly one, so each
  // axis jumps onto its sample (sample << 8 in Q16.8), its variance drops to zero, and
  // it freezes from then on.
  localparam filt_res_t NO_RES   = '0;
  localparam filt_res_t JUMP_RES = '{1'b1, 24'h000000, 24'h7FFF00, 24'h800000};
  localparam filt_res_t NEG1_RES = '{1'b1, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00};

  localparam int unsigned DIR_ROWS = 23;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    // default registers straight out of reset, sample extremes
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh8000, 16'sh7FFF, 16'sh0001, 1'b0, NO_RES},
    // zero measurement noise: the estimate lands on the sample, then the axis freezes
    '{OP_WRITE, tsk_pkg::REG_MNOISE_X, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_MNOISE_Y, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_MNOISE_Z, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1, JUMP_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh0064, 16'shFF9C, 16'sh3039, 1'b1, JUMP_RES},
    // a write past the last register must not restart the frozen axes
    '{OP_WRITE, REG_SPARE_HI, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh0001, 16'sh0001, 16'sh0001, 1'b1, JUMP_RES},
    // new range restarts every axis; noise is still zero, so it jumps again
    '{OP_WRITE, tsk_pkg::REG_RANGE, 16'h0003, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1, NEG1_RES},
    // every noise register at full scale
    '{OP_WRITE, tsk_pkg::REG_PNOISE, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_MNOISE_X, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_MNOISE_Y, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_MNOISE_Z, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, NO_RES},
    // remaining ranges, upper data bits set to check truncation; no process noise
    '{OP_WRITE, tsk_pkg::REG_RANGE, 16'hFFF5, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_PNOISE, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0, NO_RES},
    '{OP_WRITE, tsk_pkg::REG_RANGE, 16'h0002, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NO_RES},
    '{OP_SAMPLE, tsk_pkg::REG_RANGE, 16'h0000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, NO_RES}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              s_axis_tvalid_i;
  logic                              s_axis_tready_o;
  logic [tsk_pkg::IN_DATA_W-1:0]     s_axis_tdata_i;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i;
  logic [tsk_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [tsk_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [tsk_pkg::NOISE_W-1:0]       cfg_data_i;

  // Filter model state: registers, per-axis estimate (Q16.16) and variance (Q16.16).
  logic [tsk_pkg::RANGE_W-1:0]        rng_q;
  logic [tsk_pkg::NOISE_W-1:0]        pn_q;
  logic [tsk_pkg::NOISE_W-1:0]        mn_q  [tsk_pkg::NUM_AXES];
  logic signed [tsk_pkg::EST_W-1:0]   est_q [tsk_pkg::NUM_AXES];
  logic [tsk_pkg::VAR_W-1:0]          var_q [tsk_pkg::NUM_AXES];

  // Results still owed by the block, oldest first.
  filt_res_t   filt_q [$];
  filt_res_t   rx_got;
  filt_res_t   rx_want;
  int unsigned errors   = 0;
  int unsigned rx_count = 0;

  // Gap behavior of each side, changed per phase by the stimulus.
  int unsigned tx_idle_pct = 20;
  int unsigned rx_idle_pct = 20;

  three_axis_scalar_kalman DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every axis back to its starting point: estimate 32768 >> (range + 1), variance 1.0.
  function automatic void restart_filter();
    int a;
    for (a = 0; a < tsk_pkg::NUM_AXES; a++) begin
      est_q[a] = tsk_pkg::EST_W'((32768 >> (int'(rng_q) + 1)) << tsk_pkg::FRAC_W);
      var_q[a] = tsk_pkg::VAR_W'(1) << tsk_pkg::FRAC_W;
    end
  endfunction

  // Register write as seen by the filter; unknown indexes change nothing.
  function automatic void apply_cfg(input logic [tsk_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [tsk_pkg::NOISE_W-1:0] data);
    bit known;
    known = 1'b1;
    case (idx)
      tsk_pkg::REG_RANGE:    rng_q = data[tsk_pkg::RANGE_W-1:0];
      tsk_pkg::REG_PNOISE:   pn_q = data;
      tsk_pkg::REG_MNOISE_X: mn_q[0] = data;
      tsk_pkg::REG_MNOISE_Y: mn_q[1] = data;
      tsk_pkg::REG_MNOISE_Z: mn_q[2] = data;
      default:               known = 1'b0;
    endcase
    if (known) restart_filter();
  endfunction

  // One Kalman step on all three axes; returns the Q16.8 estimates and the settled flag.
  function automatic filt_res_t step_filter(input logic signed [tsk_pkg::SAMPLE_W-1:0] sx,
                                            sy, sz);
    logic signed [tsk_pkg::SAMPLE_W-1:0] smp   [tsk_pkg::NUM_AXES];
    logic [tsk_pkg::OUT_W-1:0]           shown [tsk_pkg::NUM_AXES];
    longint unsigned                     p1, den, gain;
    longint                              diff, nx, q;
    bit                                  settled;
    int                                  a;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    settled = 1'b1;
    for (a = 0; a < tsk_pkg::NUM_AXES; a++) begin
      // Frozen axes keep estimate and variance as they are.
      if (var_q[a] > tsk_pkg::VAR_THRESHOLD) begin
        p1 = 64'(var_q[a]) + (64'(pn_q) << tsk_pkg::PNOISE_SH);
        if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
        den  = p1 + (64'(mn_q[a]) << tsk_pkg::FRAC_W);
        gain = (p1 << tsk_pkg::FRAC_W) / den;
        if (gain > 64'(tsk_pkg::GAIN_ONE)) gain = 64'(tsk_pkg::GAIN_ONE);
        diff = longint'(smp[a]) * 65536 - longint'(est_q[a]);
        nx   = longint'(est_q[a]) + ((longint'(gain) * diff) >>> tsk_pkg::FRAC_W);
        if (nx > EST_MAX) nx = EST_MAX;
        if (nx < EST_MIN) nx = EST_MIN;
        est_q[a] = nx[tsk_pkg::EST_W-1:0];
        var_q[a] = tsk_pkg::VAR_W'(((64'(tsk_pkg::GAIN_ONE) - gain) * p1)
                                   >> tsk_pkg::FRAC_W);
      end
      if (var_q[a] > tsk_pkg::VAR_THRESHOLD) settled = 1'b0;
      q = longint'(est_q[a]) >>> tsk_pkg::OUT_SH;
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      shown[a] = q[tsk_pkg::OUT_W-1:0];
    end
    return '{settled, shown[2], shown[1], shown[0]};
  endfunction

  // Mostly no gap; short gaps often, long ones now and then.
  function automatic int unsigned idle_len(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(40, 200);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // Register value: either extreme, the reset value, or anything.
  function automatic logic [tsk_pkg::NOISE_W-1:0] pick_word(
      input logic [tsk_pkg::NOISE_W-1:0] dflt);
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return dflt;
      default: return tsk_pkg::NOISE_W'($urandom);
    endcase
  endfunction

  // Hold until the block has returned every result it owes.
  task automatic wait_drained();
    while (filt_q.size() != 0) @(negedge clk_i);
  endtask

  // Offer one request; on acceptance, record what the block must answer.
  // Entered and left at a falling edge; valid stays high when no gap follows.
  task automatic send_sample(input logic signed [tsk_pkg::SAMPLE_W-1:0] sx, sy, sz,
                             input logic typed, input filt_res_t want);
    filt_res_t pred;
    int unsigned gap;
    s_axis_tdata_i  = tsk_pkg::IN_DATA_W'({sz, sy, sx});
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = step_filter(sx, sy, sz);
    filt_q.push_back(typed ? want : pred);
    @(negedge clk_i);
    gap = idle_len(tx_idle_pct);
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_reg(input logic [tsk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsk_pkg::NOISE_W-1:0] data);
    s_axis_tvalid_i = 1'b0;
    wait_drained();
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_cfg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic check_field(input string what, input logic [tsk_pkg::OUT_W-1:0] want,
                             input logic [tsk_pkg::OUT_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("result %0d %s: expected %h, got %h", rx_count, what, want, got);
    end
  endtask

  // Compare each result taken off the output against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      rx_count++;
      rx_got = filt_res_t'(m_axis_tdata_o[$bits(filt_res_t)-1:0]);
      if (filt_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("result %0d not owed: %h", rx_count, rx_got);
      end else begin
        rx_want = filt_q.pop_front();
        check_field("filtered_x", rx_want.fx, rx_got.fx);
        check_field("filtered_y", rx_want.fy, rx_got.fy);
        check_field("filtered_z", rx_want.fz, rx_got.fz);
        check_field("all_settled", tsk_pkg::OUT_W'(rx_want.settled),
                    tsk_pkg::OUT_W'(rx_got.settled));
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off so the output register and the
  // request side back up while requests keep coming.
  initial begin
    int unsigned stall;
    bit          held;
    stall = 0;
    held  = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && rx_count >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall != 0) begin
        m_axis_tready_i = 1'b0;
        stall--;
      end else begin
        m_axis_tready_i = 1'b1;
        stall = idle_len(rx_idle_pct);
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t                            row;
    logic signed [tsk_pkg::SAMPLE_W-1:0] base [tsk_pkg::NUM_AXES];
    logic signed [tsk_pkg::SAMPLE_W-1:0] smp  [tsk_pkg::NUM_AXES];
    int unsigned                         ph, n, a, pick;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = tsk_pkg::REG_RANGE;
    cfg_data_i      = '0;

    rng_q   = '0;
    pn_q    = DEF_PNOISE;
    mn_q[0] = DEF_MNOISE_X;
    mn_q[1] = DEF_MNOISE_Y;
    mn_q[2] = DEF_MNOISE_Z;
    restart_filter();

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows first.
    for (n = 0; n < DIR_ROWS; n++) begin
      row = DIR_TBL[n];
      if (row.op == OP_WRITE) write_reg(row.idx, row.wdata);
      else send_sample(row.sx, row.sy, row.sz, row.typed, row.want);
    end

    // Random phases. Every fourth-plus-one phase runs without process noise and with tiny
    // measurement noise so the axes actually settle and freeze.
    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(tsk_pkg::REG_RANGE, pick_word('0));
      if (ph % 4 == 1) begin
        write_reg(tsk_pkg::REG_PNOISE, '0);
        write_reg(tsk_pkg::REG_MNOISE_X, tsk_pkg::NOISE_W'($urandom_range(2)));
        write_reg(tsk_pkg::REG_MNOISE_Y, tsk_pkg::NOISE_W'($urandom_range(2)));
        write_reg(tsk_pkg::REG_MNOISE_Z, tsk_pkg::NOISE_W'($urandom_range(2)));
      end else begin
        write_reg(tsk_pkg::REG_PNOISE, pick_word(DEF_PNOISE));
        write_reg(tsk_pkg::REG_MNOISE_X, pick_word(DEF_MNOISE_X));
        write_reg(tsk_pkg::REG_MNOISE_Y, pick_word(DEF_MNOISE_Y));
        write_reg(tsk_pkg::REG_MNOISE_Z, pick_word(DEF_MNOISE_Z));
      end
      if ($urandom_range(1) == 1)
        write_reg(tsk_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  tsk_pkg::NOISE_W'($urandom));
      tx_idle_pct = pick_pct();
      rx_idle_pct = pick_pct();
      for (a = 0; a < tsk_pkg::NUM_AXES; a++) base[a] = tsk_pkg::SAMPLE_W'($urandom);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, stop sending until every result is back.
        if (n == PHASE_ITEMS / 2) begin
          s_axis_tvalid_i = 1'b0;
          wait_drained();
        end
        // Drift: move one axis to a new resting level now and then.
        if ($urandom_range(39) == 0)
          base[$urandom_range(tsk_pkg::NUM_AXES - 1)] = tsk_pkg::SAMPLE_W'($urandom);
        pick = $urandom_range(99);
        for (a = 0; a < tsk_pkg::NUM_AXES; a++) begin
          if (pick < 75) begin
            smp[a] = base[a] + tsk_pkg::SAMPLE_W'($urandom_range(NOISE_SPAN))
                     - tsk_pkg::SAMPLE_W'(NOISE_SPAN / 2);
          end else if (pick < 90) begin
            smp[a] = tsk_pkg::SAMPLE_W'($urandom);
          end else begin
            case ($urandom_range(3))
              0:       smp[a] = 16'sh8000;
              1:       smp[a] = 16'sh7FFF;
              2:       smp[a] = '0;
              default: smp[a] = '1;
            endcase
          end
        end
        send_sample(smp[0], smp[1], smp[2], 1'b0, NO_RES);
      end
    end

    // Drain, then give a late or extra result time to show up.
    s_axis_tvalid_i = 1'b0;
    wait_drained();
    repeat (END_PAD) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
